### design/scl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial configuration link controller.
// No dependencies; every other design file refers to this package by scoped names.
package scl_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hA5;
    localparam logic [7:0] FRAME_VERSION = 8'd1;
    localparam logic [2:0] FLASH_PHASES  = 3'd6;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 3'd4;

    // decoupling queue between front and back (depth is a power of two)
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = 1;
    localparam int unsigned QUEUE_CW    = 2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       red_key;
        logic       blue_key;
    } t_in;

    typedef struct packed {
        logic       online;
        logic       flashing;
        logic       red_phase;
        logic       team;
        logic [7:0] armor_id;
        logic       id_loaded;
    } t_out;

    // classified item as it travels from front to back
    typedef struct packed {
        logic       is_tick;
        logic       is_sync;
        logic [7:0] data_byte;
        logic       red_key;
        logic       blue_key;
    } t_item;

    typedef struct packed {
        logic [7:0]  command_code;
        logic [7:0]  max_id;
        logic [15:0] timeout_ms;
        logic [15:0] flash_half_ms;
        logic [15:0] debounce_ms;
    } t_cfg;

endpackage

### design/scl_front.sv
`timescale 1ns / 1ps
// Front stage: accepts input items, classifies them as byte or tick and flags
// the sync byte. Depends on scl_pkg.
module scl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  scl_pkg::t_in  i_item,
    output logic          o_push,
    output scl_pkg::t_item o_item,
    input  logic          i_full
);

    logic           r_valid;
    scl_pkg::t_item r_item;
    logic           accept;

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.is_tick   <= i_item.cmd;
            r_item.is_sync   <= (i_item.data_byte == scl_pkg::SYNC_BYTE);
            r_item.data_byte <= i_item.data_byte;
            r_item.red_key   <= i_item.red_key;
            r_item.blue_key  <= i_item.blue_key;
        end
    end

endmodule

### design/scl_queue.sv
`timescale 1ns / 1ps
// Short queue between the front and back stages so each side can stall alone.
// Depends on scl_pkg.
module scl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scl_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output scl_pkg::t_item o_item,
    input  logic           i_take
);

    scl_pkg::t_item                   r_mem [scl_pkg::QUEUE_DEPTH];
    logic [scl_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [scl_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [scl_pkg::QUEUE_CW-1:0]     r_count;
    logic                             pop;

    assign o_full  = (r_count == scl_pkg::QUEUE_CW'(scl_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### design/scl_back.sv
`timescale 1ns / 1ps
// Back stage: frame hunter with running checksum, master timeout, flash timer
// and key debounce, plus the result register. Depends on scl_pkg.
module scl_back #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  scl_pkg::t_item i_q_item,
    output logic           o_q_take,
    input  scl_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_stall,
    output scl_pkg::t_out  o_result
);

    localparam int unsigned FILL_W = $clog2(FRAME_BYTES + 1);

    // frame hunter
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_cmd_byte, n_cmd_byte;
    logic              r_team_ok, n_team_ok;
    logic              r_team_bit, n_team_bit;
    logic [7:0]        r_id_byte, n_id_byte;
    logic              r_ver_ok, n_ver_ok;
    // link state
    logic [31:0]       r_elapsed, n_elapsed;
    logic [31:0]       r_last, n_last;
    logic [31:0]       r_key_time, n_key_time;
    logic [31:0]       r_next_flash, n_next_flash;
    logic [2:0]        r_phase, n_phase;
    logic              r_team, n_team;
    logic [7:0]        r_id, n_id;
    logic              r_online, n_online;
    logic              r_flashing, n_flashing;
    logic [1:0]        r_latch, n_latch;
    logic              loaded;
    // result register
    logic              r_out_valid;
    scl_pkg::t_out     r_out;

    logic [FILL_W-1:0] fill_inc;
    logic              frame_good;
    logic [31:0]       tick_time;
    logic [31:0]       since_master;
    logic [31:0]       to_deadline;
    logic [31:0]       since_keys;
    logic              flash_start;
    logic              flash_on;
    logic              flash_due;
    logic [2:0]        phase_inc;

    assign o_q_take = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign fill_inc     = r_fill + 1'b1;
    assign tick_time    = r_elapsed + 32'd1;
    assign since_master = tick_time - r_last;
    assign to_deadline  = tick_time - r_next_flash;
    assign since_keys   = tick_time - r_key_time;
    assign frame_good   = (r_cmd_byte == i_cfg.command_code) && r_team_ok &&
                          (r_id_byte <= i_cfg.max_id) && r_ver_ok &&
                          (r_sum == i_q_item.data_byte);

    always_comb begin
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_cmd_byte   = r_cmd_byte;
        n_team_ok    = r_team_ok;
        n_team_bit   = r_team_bit;
        n_id_byte    = r_id_byte;
        n_ver_ok     = r_ver_ok;
        n_elapsed    = r_elapsed;
        n_last       = r_last;
        n_key_time   = r_key_time;
        n_next_flash = r_next_flash;
        n_phase      = r_phase;
        n_team       = r_team;
        n_id         = r_id;
        n_online     = r_online;
        n_flashing   = r_flashing;
        n_latch      = r_latch;
        loaded       = 1'b0;
        flash_start  = 1'b0;
        flash_on     = 1'b0;
        flash_due    = 1'b0;
        phase_inc    = 3'd0;

        if (!i_q_item.is_tick) begin
            if (r_fill == '0) begin
                if (i_q_item.is_sync) begin
                    n_fill = FILL_W'(1);
                    n_sum  = scl_pkg::SYNC_BYTE;
                end
            end else begin
                // capture the header fields as they pass
                if (r_fill == FILL_W'(1)) begin
                    n_cmd_byte = i_q_item.data_byte;
                end
                if (r_fill == FILL_W'(2)) begin
                    n_team_ok  = (i_q_item.data_byte <= 8'd1);
                    n_team_bit = i_q_item.data_byte[0];
                end
                if (r_fill == FILL_W'(3)) begin
                    n_id_byte = i_q_item.data_byte;
                end
                if (r_fill == FILL_W'(4)) begin
                    n_ver_ok = (i_q_item.data_byte == scl_pkg::FRAME_VERSION);
                end
                if (fill_inc != FILL_W'(FRAME_BYTES)) begin
                    n_fill = fill_inc;
                    n_sum  = r_sum + i_q_item.data_byte;
                end else begin
                    if (frame_good) begin
                        n_team     = r_team_bit;
                        n_id       = r_id_byte;
                        n_last     = r_elapsed;
                        n_online   = 1'b1;
                        n_flashing = 1'b0;
                        n_phase    = 3'd0;
                        loaded     = 1'b1;
                    end
                    // a trailing sync byte opens the next hunt
                    if (i_q_item.is_sync) begin
                        n_fill = FILL_W'(1);
                        n_sum  = scl_pkg::SYNC_BYTE;
                    end else begin
                        n_fill = '0;
                    end
                end
            end
        end else begin
            n_elapsed   = tick_time;
            flash_start = r_online && !r_flashing &&
                          (since_master >= 32'(i_cfg.timeout_ms));
            flash_on    = r_flashing || flash_start;
            // on the starting tick the deadline is now only for a zero period
            flash_due   = flash_start ? (i_cfg.flash_half_ms == 16'd0) : !to_deadline[31];
            if (flash_start) begin
                n_phase      = 3'd0;
                n_flashing   = 1'b1;
                n_next_flash = tick_time + 32'(i_cfg.flash_half_ms);
            end
            if (flash_on && flash_due) begin
                phase_inc    = (flash_start ? 3'd0 : r_phase) + 3'd1;
                n_next_flash = tick_time + 32'(i_cfg.flash_half_ms);
                if (phase_inc >= scl_pkg::FLASH_PHASES) begin
                    n_flashing = 1'b0;
                    n_online   = 1'b0;
                    n_phase    = 3'd0;
                end else begin
                    n_phase = phase_inc;
                end
            end
            if (!n_online && !n_flashing && (since_keys >= 32'(i_cfg.debounce_ms))) begin
                n_key_time = tick_time;
                if (i_q_item.red_key && !i_q_item.blue_key && !r_latch[0]) begin
                    n_team  = 1'b0;
                    n_latch = 2'b01;
                end else if (i_q_item.blue_key && !i_q_item.red_key && !r_latch[1]) begin
                    n_team  = 1'b1;
                    n_latch = 2'b10;
                end
                // drop a latch once its key is released
                if (!i_q_item.red_key) begin
                    n_latch[0] = 1'b0;
                end
                if (!i_q_item.blue_key) begin
                    n_latch[1] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_elapsed    <= '0;
            r_last       <= '0;
            r_key_time   <= '0;
            r_next_flash <= '0;
            r_phase      <= '0;
            r_team       <= 1'b1;
            r_id         <= '0;
            r_online     <= 1'b0;
            r_flashing   <= 1'b0;
            r_latch      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_take) begin
                r_fill       <= n_fill;
                r_elapsed    <= n_elapsed;
                r_last       <= n_last;
                r_key_time   <= n_key_time;
                r_next_flash <= n_next_flash;
                r_phase      <= n_phase;
                r_team       <= n_team;
                r_id         <= n_id;
                r_online     <= n_online;
                r_flashing   <= n_flashing;
                r_latch      <= n_latch;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_take) begin
            r_sum            <= n_sum;
            r_cmd_byte       <= n_cmd_byte;
            r_team_ok        <= n_team_ok;
            r_team_bit       <= n_team_bit;
            r_id_byte        <= n_id_byte;
            r_ver_ok         <= n_ver_ok;
            r_out.online     <= n_online;
            r_out.flashing   <= n_flashing;
            r_out.red_phase  <= !n_phase[0];
            r_out.team       <= n_team;
            r_out.armor_id   <= n_id;
            r_out.id_loaded  <= loaded;
        end
    end

`ifndef SYNTH
    a_flash_needs_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flashing |-> r_online)
        else $error("flashing while offline");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < scl_pkg::FLASH_PHASES)
        else $error("flash phase out of range");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(FRAME_BYTES))
        else $error("frame fill count out of range");

    a_one_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latch != 2'b11)
        else $error("both key latches set");

    a_loaded_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.id_loaded) |-> (r_out.online && !r_out.flashing))
        else $error("id loaded without online link");
`endif

endmodule

### design/serial_config_link_controller.sv
`timescale 1ns / 1ps
// Serial configuration link controller, top level.
// Input channel (i_valid / o_stall / i_item): one item per accept, either a
// received byte (cmd 0) or a one-millisecond tick with key levels (cmd 1).
// Output channel (o_valid / i_stall / o_result): exactly one result per item,
// in order, giving the link state after that item was applied.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 command code, 1 max id, 2 timeout, 3 flash half period, 4 debounce);
// other indexes are ignored. Write only while no item is in flight.
// Path: the front register loads at the accepting edge, then the queue, then
// the result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the back stage applying each item's full update as it takes the item.
// Reset (synchronous, active low) empties all stages, restores the register
// defaults, clears the hunter and timers and selects the blue team.
// When the receiver stalls, the result register holds, the queue fills and
// the front then raises o_stall; no item or result is lost.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
module serial_config_link_controller #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  scl_pkg::t_in                       i_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output scl_pkg::t_out                      o_result,
    input  logic                               i_cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    scl_pkg::t_cfg  r_cfg;
    logic           push;
    logic           full;
    scl_pkg::t_item front_item;
    logic           q_valid;
    scl_pkg::t_item q_item;
    logic           q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.command_code  <= 8'd1;
            r_cfg.max_id        <= 8'd7;
            r_cfg.timeout_ms    <= 16'd1000;
            r_cfg.flash_half_ms <= 16'd250;
            r_cfg.debounce_ms   <= 16'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scl_pkg::CFG_COMMAND_CODE:  r_cfg.command_code  <= i_cfg_data[7:0];
                scl_pkg::CFG_MAX_ID:        r_cfg.max_id        <= i_cfg_data[7:0];
                scl_pkg::CFG_TIMEOUT_MS:    r_cfg.timeout_ms    <= i_cfg_data;
                scl_pkg::CFG_FLASH_HALF_MS: r_cfg.flash_half_ms <= i_cfg_data;
                scl_pkg::CFG_DEBOUNCE_MS:   r_cfg.debounce_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    scl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (full)
    );

    scl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    scl_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_take  (q_take),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (o_result)
    );

endmodule

### tb/sv/scl_link_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the serial configuration link controller: tracks the frame
// hunter, master timeout, flash timer and key latches, and checks each result.
// Depends on scl_pkg.
module scl_link_checker #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  scl_pkg::t_in                   i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  scl_pkg::t_out                  i_out_result,
    input  logic                           i_cfg_we,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_frames,
    output int                             o_offline,
    output int                             o_key_picks
);
    import scl_pkg::*;

    t_cfg        regs;
    logic [7:0]  frame_buf [FRAME_BYTES];
    int unsigned fill;
    logic [31:0] now_ms;
    logic [31:0] master_ms;
    logic [31:0] key_ms;
    logic [31:0] flash_due;
    logic [2:0]  phase_cnt;
    logic        team_r;
    logic [7:0]  id_r;
    logic        online_r;
    logic        flashing_r;
    logic [1:0]  key_latch;

    t_out        status_q [$];
    t_out        want;
    int          fails = 0;
    int          checked = 0;
    int          frames = 0;
    int          offline = 0;
    int          picks = 0;

    function automatic void reset_link();
        regs.command_code  = 8'd1;
        regs.max_id        = 8'd7;
        regs.timeout_ms    = 16'd1000;
        regs.flash_half_ms = 16'd250;
        regs.debounce_ms   = 16'd20;
        fill       = 0;
        now_ms     = '0;
        master_ms  = '0;
        key_ms     = '0;
        flash_due  = '0;
        phase_cnt  = '0;
        team_r     = 1'b1;
        id_r       = '0;
        online_r   = 1'b0;
        flashing_r = 1'b0;
        key_latch  = '0;
    endfunction

    function automatic logic frame_good();
        logic [7:0] total;
        int         k;
        total = '0;
        for (k = 0; k < FRAME_BYTES - 1; k++)
            total = total + frame_buf[k];
        return frame_buf[0] == SYNC_BYTE && frame_buf[1] == regs.command_code &&
               frame_buf[2] <= 8'd1 && frame_buf[3] <= regs.max_id &&
               frame_buf[4] == FRAME_VERSION && total == frame_buf[FRAME_BYTES-1];
    endfunction

    function automatic logic hunt_byte(input logic [7:0] b);
        logic loaded;
        loaded = 1'b0;
        if (fill == 0) begin
            if (b == SYNC_BYTE) begin
                frame_buf[0] = b;
                fill = 1;
            end
        end else begin
            frame_buf[fill] = b;
            fill++;
            if (fill == FRAME_BYTES) begin
                if (frame_good()) begin
                    team_r     = frame_buf[2][0];
                    id_r       = frame_buf[3];
                    master_ms  = now_ms;
                    online_r   = 1'b1;
                    flashing_r = 1'b0;
                    phase_cnt  = '0;
                    loaded     = 1'b1;
                    frames++;
                end
                fill = 0;
                // a closing sync byte opens the next frame
                if (b == SYNC_BYTE) begin
                    frame_buf[0] = b;
                    fill = 1;
                end
            end
        end
        return loaded;
    endfunction

    function automatic void tick_ms(input logic red, input logic blue);
        logic [31:0] lag;
        logic [31:0] since;
        now_ms = now_ms + 32'd1;
        if (online_r && !flashing_r && (now_ms - master_ms) >= 32'(regs.timeout_ms)) begin
            flashing_r = 1'b1;
            phase_cnt  = '0;
            flash_due  = now_ms + 32'(regs.flash_half_ms);
        end
        lag = now_ms - flash_due;
        if (flashing_r && !lag[31]) begin
            phase_cnt = phase_cnt + 3'd1;
            flash_due = now_ms + 32'(regs.flash_half_ms);
            if (phase_cnt >= FLASH_PHASES) begin
                flashing_r = 1'b0;
                online_r   = 1'b0;
                phase_cnt  = '0;
                offline++;
            end
        end
        since = now_ms - key_ms;
        if (!online_r && !flashing_r && since >= 32'(regs.debounce_ms)) begin
            key_ms = now_ms;
            if (red && !blue && !key_latch[0]) begin
                team_r    = 1'b0;
                key_latch = 2'b01;
                picks++;
            end else if (blue && !red && !key_latch[1]) begin
                team_r    = 1'b1;
                key_latch = 2'b10;
                picks++;
            end
            if (!red)
                key_latch[0] = 1'b0;
            if (!blue)
                key_latch[1] = 1'b0;
        end
    endfunction

    function automatic t_out link_status(input t_in it);
        t_out st;
        logic loaded;
        loaded = 1'b0;
        if (it.cmd)
            tick_ms(it.red_key, it.blue_key);
        else
            loaded = hunt_byte(it.data_byte);
        st.online    = online_r;
        st.flashing  = flashing_r;
        st.red_phase = ~phase_cnt[0];
        st.team      = team_r;
        st.armor_id  = id_r;
        st.id_loaded = loaded;
        return st;
    endfunction

    function automatic void check_field(input string name, input int unsigned e,
                                        input int unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_link();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COMMAND_CODE:  regs.command_code  = i_cfg_data[7:0];
                    CFG_MAX_ID:        regs.max_id        = i_cfg_data[7:0];
                    CFG_TIMEOUT_MS:    regs.timeout_ms    = i_cfg_data;
                    CFG_FLASH_HALF_MS: regs.flash_half_ms = i_cfg_data;
                    CFG_DEBOUNCE_MS:   regs.debounce_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_result);
                    fails++;
                end else begin
                    want = status_q.pop_front();
                    check_field("online", 32'(want.online), 32'(i_out_result.online));
                    check_field("flashing", 32'(want.flashing),
                                32'(i_out_result.flashing));
                    check_field("red_phase", 32'(want.red_phase),
                                32'(i_out_result.red_phase));
                    check_field("team", 32'(want.team), 32'(i_out_result.team));
                    check_field("armor_id", 32'(want.armor_id),
                                32'(i_out_result.armor_id));
                    check_field("id_loaded", 32'(want.id_loaded),
                                32'(i_out_result.id_loaded));
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                status_q.push_back(link_status(i_in_item));
        end
        o_fail_count <= fails;
        o_pending    <= status_q.size();
        o_checked    <= checked;
        o_frames     <= frames;
        o_offline    <= offline;
        o_key_picks  <= picks;
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the link controller testbench: clock, reset, item and register stimulus,
// receiver stalls and the verdict. Depends on scl_pkg, scl_link_checker and the RTL.
module testbench;
    import scl_pkg::*;

    localparam int unsigned FRAME_BYTES     = 6;
    localparam int          PHASES          = 8;
    localparam int          ITEMS_PER_PHASE = 230;
    localparam int          HOLD_CYCLES     = 80;
    localparam logic        CMD_BYTE        = 1'b0;
    localparam logic        CMD_TICK        = 1'b1;

    typedef enum int {
        FLAW_NONE,
        FLAW_COMMAND,
        FLAW_TEAM,
        FLAW_ID,
        FLAW_VERSION,
        FLAW_SUM,
        FLAW_SHORT
    } t_flaw;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in                   in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int frames;
    int offline;
    int key_picks;

    int         idle_pct = 0;
    int         stall_pct = 0;
    int         hold_asked = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         sent = 0;
    logic       red_lvl = 1'b0;
    logic       blue_lvl = 1'b0;
    logic [7:0] cur_cmd = 8'd1;
    logic [7:0] cur_max = 8'd7;

    always #5 clk = ~clk;

    serial_config_link_controller #(.FRAME_BYTES(FRAME_BYTES)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_result   (out_result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    scl_link_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_result (out_result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_frames     (frames),
        .o_offline    (offline),
        .o_key_picks  (key_picks)
    );

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen = hold_seen + 1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, pending);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input t_in it);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in it;
        it.cmd       = CMD_BYTE;
        it.data_byte = b;
        it.red_key   = 1'($urandom_range(0, 1));
        it.blue_key  = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_tick(input logic red, input logic blue);
        t_in it;
        it.cmd       = CMD_TICK;
        it.data_byte = 8'($urandom_range(0, 255));
        it.red_key   = red;
        it.blue_key  = blue;
        send_item(it);
    endtask

    // sync, four body bytes, then the sum of all five
    task automatic send_sealed(input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3, input logic [7:0] b4);
        send_byte(SYNC_BYTE);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
        send_byte(b4);
        send_byte(8'(SYNC_BYTE + b1 + b2 + b3 + b4));
    endtask

    task automatic send_frame(input t_flaw flaw);
        logic [7:0] f [FRAME_BYTES];
        logic [7:0] total;
        int         n;
        int         k;
        f[0] = SYNC_BYTE;
        f[1] = cur_cmd;
        f[2] = 8'($urandom_range(0, 1));
        f[3] = 8'($urandom_range(0, cur_max));
        f[4] = FRAME_VERSION;
        n    = FRAME_BYTES;
        case (flaw)
            FLAW_COMMAND: f[1] = cur_cmd ^ 8'($urandom_range(1, 255));
            FLAW_TEAM:    f[2] = 8'($urandom_range(2, 255));
            FLAW_ID:      if (cur_max != 8'hFF) f[3] = 8'($urandom_range(cur_max + 1, 255));
            FLAW_VERSION: f[4] = FRAME_VERSION ^ 8'($urandom_range(1, 255));
            FLAW_SHORT:   n = $urandom_range(1, FRAME_BYTES - 1);
            default: ;
        endcase
        total = '0;
        for (k = 0; k < FRAME_BYTES - 1; k++)
            total = total + f[k];
        f[FRAME_BYTES-1] = total;
        if (flaw == FLAW_SUM)
            f[FRAME_BYTES-1] = $urandom_range(0, 1) ? SYNC_BYTE
                                                    : total ^ 8'($urandom_range(1, 255));
        for (k = 0; k < n; k++) begin
            // ticks between bytes must not disturb the hunter
            if ($urandom_range(0, 9) == 0)
                send_tick(red_lvl, blue_lvl);
            send_byte(f[k]);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] cmd, input logic [7:0] maxid,
                             input logic [15:0] tmo, input logic [15:0] flash,
                             input logic [15:0] deb);
        logic [CFG_IDX_W-1:0]  idxs [6];
        logic [CFG_DATA_W-1:0] vals [6];
        int                    k;
        idxs = '{CFG_COMMAND_CODE, CFG_MAX_ID, CFG_TIMEOUT_MS, CFG_FLASH_HALF_MS,
                 CFG_DEBOUNCE_MS, CFG_IDX_W'($urandom_range(5, 7))};
        // junk in the upper byte of the narrow registers must be dropped
        vals = '{{8'($urandom), cmd}, {8'($urandom), maxid}, tmo, flash, deb,
                 CFG_DATA_W'($urandom)};
        wait_idle();
        for (k = 0; k < 6; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        cur_cmd = cmd;
        cur_max = maxid;
    endtask

    initial begin
        int    ph;
        int    pick;
        int    target;
        int    phase_start;
        int    frame_pct;
        t_flaw flaw;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a valid frame with the largest id and team byte one
        send_sealed(8'd1, 8'd1, 8'd7, FRAME_VERSION);

        // zero timeout, zero flash period, zero debounce
        configure(8'h3C, 8'hFF, 16'd0, 16'd0, 16'd0);
        // id chosen so that the checksum is itself a sync byte
        send_sealed(8'h3C, 8'h00, 8'hC3, FRAME_VERSION);
        send_byte(8'h3C);
        send_byte(8'h01);
        send_byte(8'h05);
        send_byte(FRAME_VERSION);
        send_byte(8'(SYNC_BYTE + 8'h3C + 8'h01 + 8'h05 + FRAME_VERSION));
        repeat (6) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(8'h00, 8'h00, 16'd1, 16'd1, 16'd0);
                1: configure(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: configure(8'($urandom), 8'($urandom), 16'd0, 16'd0,
                             16'($urandom_range(0, 3)));
                default: configure(8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)),
                                   16'($urandom_range(0, 10)), 16'($urandom_range(0, 15)));
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            if (ph == 4)
                hold_asked++;
            frame_pct   = $urandom_range(15, 50);
            phase_start = sent;
            target      = sent + ITEMS_PER_PHASE;
            while (sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < frame_pct) begin
                    flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE
                         : t_flaw'($urandom_range(FLAW_COMMAND, FLAW_SHORT));
                    send_frame(flaw);
                end else if (pick < 94) begin
                    repeat ($urandom_range(1, 10)) begin
                        if ($urandom_range(0, 4) == 0)
                            red_lvl = ~red_lvl;
                        if ($urandom_range(0, 4) == 0)
                            blue_lvl = ~blue_lvl;
                        send_tick(red_lvl, blue_lvl);
                    end
                end else begin
                    send_byte($urandom_range(0, 3) == 0 ? SYNC_BYTE
                                                        : 8'($urandom_range(0, 255)));
                end
                // second hold-off halfway through the pressure phase
                if (ph == 4 && hold_asked == 1 && sent - phase_start > 100)
                    hold_asked++;
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d items over %0d register settings, %0d results checked.",
                 sent, PHASES + 2, checked);
        $display("Frames loaded: %0d, offline transitions: %0d, team picks by key: %0d.",
                 frames, offline, key_picks);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
